>>> rtl/core/dq_pkg.sv
// dq_pkg: shared widths, register map, float constants and flag struct
// of the int4 group dequantizer; no dependencies
`default_nettype none

package dq_pkg;

    localparam int MAX_ROW_WORDS_DEF = 4096;

    localparam int LANES   = 8;
    localparam int NIB_W   = 4;
    localparam int WORD_W  = 32;
    localparam int BF_W    = 16;
    localparam int FP_W    = 32;
    localparam int ROW_W   = 13;
    localparam int GRP_W   = 7;
    localparam int REM_W   = GRP_W + 1;
    localparam int SIG_W   = 8;
    localparam int MANT_W  = 12;
    localparam int EXP_W   = 10;
    localparam int ALIGN_CAP = 40;
    localparam int SUM_W   = MANT_W + ALIGN_CAP + 1;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic REG_ROW_WORDS   = 1'b0;
    localparam logic REG_GROUP_WORDS = 1'b1;

    localparam logic [ROW_W-1:0] ROW_WORDS_RST   = ROW_W'(8);
    localparam logic [GRP_W-1:0] GROUP_WORDS_RST = GRP_W'(8);

    localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [7:0]      EXP_MAX = 8'hFF;

    typedef struct packed {
        logic row_end;
        logic rem_zero;
        logic matrix_end;
    } pos_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/dq_word_if.sv
// dq_word_if: input channel, one packed word with scale and bias per item
// depends on dq_pkg
`default_nettype none

interface dq_word_if;
    logic                           valid;
    logic                           ready;
    logic [dq_pkg::WORD_W-1:0]      packed_word;
    logic [dq_pkg::BF_W-1:0]        scale_bits;
    logic [dq_pkg::BF_W-1:0]        bias_bits;
    logic                           last_word;

    modport source (output valid, packed_word, scale_bits, bias_bits, last_word, input ready);
    modport sink (input valid, packed_word, scale_bits, bias_bits, last_word, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dq_result_if.sv
// dq_result_if: output channel, eight fp32 weights and position flags per item
// depends on dq_pkg
`default_nettype none

interface dq_result_if;
    logic                       valid;
    logic                       ready;
    logic [dq_pkg::FP_W-1:0]    weight_0;
    logic [dq_pkg::FP_W-1:0]    weight_1;
    logic [dq_pkg::FP_W-1:0]    weight_2;
    logic [dq_pkg::FP_W-1:0]    weight_3;
    logic [dq_pkg::FP_W-1:0]    weight_4;
    logic [dq_pkg::FP_W-1:0]    weight_5;
    logic [dq_pkg::FP_W-1:0]    weight_6;
    logic [dq_pkg::FP_W-1:0]    weight_7;
    logic                       row_end;
    logic                       group_end;
    logic                       matrix_end;

    modport source (output valid, weight_0, weight_1, weight_2, weight_3, weight_4, weight_5,
                    weight_6, weight_7, row_end, group_end, matrix_end, input ready);
    modport sink (input valid, weight_0, weight_1, weight_2, weight_3, weight_4, weight_5,
                  weight_6, weight_7, row_end, group_end, matrix_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dq_lane.sv
// dq_lane: one nibble times bf16 scale plus bf16 bias, fp32 round to nearest even
// three register stages: multiply, align and add, normalize and round; uses dq_pkg
`default_nettype none

module dq_lane (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [dq_pkg::NIB_W-1:0]   nibble,
    input  wire logic [dq_pkg::BF_W-1:0]    scale_bits,
    input  wire logic [dq_pkg::BF_W-1:0]    bias_bits,
    output logic      [dq_pkg::FP_W-1:0]    result
);

    localparam int NORM_W = dq_pkg::SUM_W + 25;

    // stage 1: exact product and operand decode
    logic [dq_pkg::SIG_W-1:0]         s_sig;
    logic [dq_pkg::SIG_W-1:0]         b_sig;
    logic [7:0]                       s_exp_eff;
    logic [7:0]                       b_exp_eff;
    logic                             s_nan;
    logic                             s_inf;

    logic [dq_pkg::MANT_W-1:0]        pm_reg;
    logic signed [dq_pkg::EXP_W-1:0]  pe_reg;
    logic                             ps_reg;
    logic                             pnan_reg;
    logic                             pinf_reg;
    logic [dq_pkg::SIG_W-1:0]         bm_reg;
    logic signed [dq_pkg::EXP_W-1:0]  be_reg;
    logic                             bs_reg;
    logic                             bnan_reg;
    logic                             binf_reg;

    always_comb
    begin
        s_sig     = {scale_bits[14:7] != 8'd0, scale_bits[6:0]};
        b_sig     = {bias_bits[14:7] != 8'd0, bias_bits[6:0]};
        s_exp_eff = (scale_bits[14:7] == 8'd0) ? 8'd1 : scale_bits[14:7];
        b_exp_eff = (bias_bits[14:7] == 8'd0) ? 8'd1 : bias_bits[14:7];
        s_nan     = (scale_bits[14:7] == dq_pkg::EXP_MAX) && (scale_bits[6:0] != 7'd0);
        s_inf     = (scale_bits[14:7] == dq_pkg::EXP_MAX) && (scale_bits[6:0] == 7'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_reg   <= dq_pkg::MANT_W'(nibble) * dq_pkg::MANT_W'(s_sig);
            pe_reg   <= $signed({2'b00, s_exp_eff}) - 10'sd134;
            ps_reg   <= scale_bits[15];
            pnan_reg <= s_nan || (s_inf && nibble == '0);
            pinf_reg <= s_inf && nibble != '0;
            bm_reg   <= b_sig;
            be_reg   <= $signed({2'b00, b_exp_eff}) - 10'sd134;
            bs_reg   <= bias_bits[15];
            bnan_reg <= (bias_bits[14:7] == dq_pkg::EXP_MAX) && (bias_bits[6:0] != 7'd0);
            binf_reg <= (bias_bits[14:7] == dq_pkg::EXP_MAX) && (bias_bits[6:0] == 7'd0);
        end
    end

    // stage 2: align the smaller-exponent operand and add or subtract
    logic [3:0]                       pm_msb;
    logic signed [dq_pkg::EXP_W-1:0]  p_top;
    logic                             p_inf;
    logic signed [dq_pkg::EXP_W-1:0]  pe_e;
    logic signed [dq_pkg::EXP_W-1:0]  be_e;
    logic [dq_pkg::MANT_W-1:0]        h_m;
    logic [dq_pkg::MANT_W-1:0]        l_m;
    logic signed [dq_pkg::EXP_W-1:0]  h_e;
    logic signed [dq_pkg::EXP_W-1:0]  l_e;
    logic                             h_s;
    logic                             l_s;
    logic signed [dq_pkg::EXP_W-1:0]  dd;
    logic [5:0]                       sh_amt;
    logic [dq_pkg::SUM_W-1:0]         x_op;
    logic [dq_pkg::SUM_W-1:0]         y_op;
    logic [dq_pkg::SUM_W-1:0]         m_c;
    logic                             sg_c;

    logic [dq_pkg::SUM_W-1:0]         m_reg;
    logic signed [dq_pkg::EXP_W-1:0]  el_reg;
    logic                             sg_reg;
    logic                             nan_reg;
    logic                             inf_reg;
    logic                             isg_reg;

    always_comb
    begin
        pm_msb = 4'd0;
        for (int i = 0; i < dq_pkg::MANT_W; i++)
        begin
            if (pm_reg[i])
                pm_msb = 4'(i);
        end
        p_top = pe_reg + $signed({6'd0, pm_msb});
        p_inf = pinf_reg || ((pm_reg != '0) && (p_top >= 10'sd128));

        pe_e = (pm_reg == '0) ? be_reg : pe_reg;
        be_e = (bm_reg == '0) ? pe_e : be_reg;

        if (pe_e >= be_e)
        begin
            h_m = pm_reg;
            h_e = pe_e;
            h_s = ps_reg;
            l_m = dq_pkg::MANT_W'(bm_reg);
            l_e = be_e;
            l_s = bs_reg;
        end
        else
        begin
            h_m = dq_pkg::MANT_W'(bm_reg);
            h_e = be_e;
            h_s = bs_reg;
            l_m = pm_reg;
            l_e = pe_e;
            l_s = ps_reg;
        end

        dd = h_e - l_e;
        if (dd > 10'sd40)
        begin
            sh_amt = 6'(dq_pkg::ALIGN_CAP);
            l_m    = dq_pkg::MANT_W'(l_m != '0);
        end
        else
        begin
            sh_amt = dd[5:0];
        end

        x_op = dq_pkg::SUM_W'(h_m) << sh_amt;
        y_op = dq_pkg::SUM_W'(l_m);

        if (h_s == l_s)
        begin
            m_c  = x_op + y_op;
            sg_c = h_s;
        end
        else if (x_op >= y_op)
        begin
            m_c  = x_op - y_op;
            sg_c = h_s;
        end
        else
        begin
            m_c  = y_op - x_op;
            sg_c = l_s;
        end
        if (m_c == '0)
            sg_c = h_s & l_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= m_c;
            el_reg  <= h_e - $signed({4'd0, sh_amt});
            sg_reg  <= sg_c;
            nan_reg <= pnan_reg || bnan_reg || (p_inf && binf_reg && (ps_reg != bs_reg));
            inf_reg <= p_inf || binf_reg;
            isg_reg <= p_inf ? ps_reg : bs_reg;
        end
    end

    // stage 3: normalize, round and pack
    logic [5:0]                 lead;
    logic signed [10:0]         exp_c;
    logic signed [10:0]         exp_r;
    logic [NORM_W-1:0]          norm;
    logic [dq_pkg::SUM_W-1:0]   smask;
    logic                       sticky;
    logic                       rnd;
    logic [24:0]                mant25;
    logic [dq_pkg::EXP_W-1:0]   sa_full;
    logic [dq_pkg::SUM_W-1:0]   sub_val;
    logic [22:0]                frac;
    logic [dq_pkg::FP_W-1:0]    res_c;
    logic [dq_pkg::FP_W-1:0]    res_reg;

    always_comb
    begin
        lead = 6'd0;
        for (int i = 0; i < dq_pkg::SUM_W; i++)
        begin
            if (m_reg[i])
                lead = 6'(i);
        end
        exp_c = $signed({el_reg[dq_pkg::EXP_W-1], el_reg}) + $signed({5'd0, lead}) + 11'sd127;

        norm   = {m_reg, 25'd0} >> (7'(lead) + 7'd1);
        smask  = (lead > 6'd24) ? ((dq_pkg::SUM_W'(1) << (lead - 6'd24)) - dq_pkg::SUM_W'(1))
                                : '0;
        sticky = |(m_reg & smask);
        rnd    = norm[0] && (sticky || norm[1]);
        mant25 = {1'b0, norm[24:1]} + 25'(rnd);
        exp_r  = exp_c + $signed({10'd0, mant25[24]});
        frac   = mant25[24] ? mant25[23:1] : mant25[22:0];

        sa_full = el_reg + 10'sd149;
        sub_val = m_reg << sa_full[4:0];

        if (nan_reg)
            res_c = dq_pkg::FP_QNAN;
        else if (inf_reg)
            res_c = {isg_reg, dq_pkg::EXP_MAX, 23'd0};
        else if (m_reg == '0)
            res_c = {sg_reg, 31'd0};
        else if (exp_c < 11'sd1)
            res_c = {sg_reg, 8'd0, sub_val[22:0]};
        else if (exp_r >= 11'sd255)
            res_c = {sg_reg, dq_pkg::EXP_MAX, 23'd0};
        else
            res_c = {sg_reg, exp_r[7:0], frac};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_c;
    end

    assign result = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/dq_pos.sv
// dq_pos: word position counter, row end detection and pipelined group remainder
// three register stages to line up with dq_lane; uses dq_pkg
`default_nettype none

module dq_pos #(
    parameter int MAX_ROW_WORDS = dq_pkg::MAX_ROW_WORDS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       accept,
    input  wire logic                       last_word,
    input  wire logic [dq_pkg::ROW_W-1:0]   row_words,
    input  wire logic [dq_pkg::GRP_W-1:0]   group_words,
    output dq_pkg::pos_flags_t              flags
);

    localparam int CNT_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int NXT_W = CNT_W + 1;
    localparam int EFF_W = (dq_pkg::ROW_W > NXT_W) ? dq_pkg::ROW_W : NXT_W;
    localparam int STEP  = (NXT_W + 2) / 3;
    localparam int PAD   = 3 * STEP;

    logic [CNT_W-1:0]           word_in_row_reg;
    logic [CNT_W-1:0]           word_in_row_next;
    logic [NXT_W-1:0]           nxt;
    logic [EFF_W-1:0]           eff_row;
    logic [dq_pkg::GRP_W-1:0]   eff_grp;
    logic                       row_end_c;
    logic [PAD-1:0]             dvd0;

    always_comb
    begin
        nxt     = NXT_W'(word_in_row_reg) + NXT_W'(1);
        eff_row = EFF_W'(row_words);
        if (row_words == '0)
            eff_row = EFF_W'(1);
        else if (eff_row > EFF_W'(MAX_ROW_WORDS))
            eff_row = EFF_W'(MAX_ROW_WORDS);
        row_end_c = EFF_W'(nxt) >= eff_row;
        eff_grp   = (group_words == '0) ? dq_pkg::GRP_W'(1) : group_words;
        dvd0      = PAD'(nxt);
        word_in_row_next = word_in_row_reg;
        if (accept)
            word_in_row_next = (row_end_c || last_word) ? '0 : nxt[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_in_row_reg <= '0;
        else
            word_in_row_reg <= word_in_row_next;
    end

    function automatic logic [dq_pkg::REM_W-1:0] rem_step(
        input logic [dq_pkg::REM_W-1:0] r,
        input logic                     b,
        input logic [dq_pkg::GRP_W-1:0] d
    );
        logic [dq_pkg::REM_W-1:0] t;
        t = {r[dq_pkg::REM_W-2:0], b};
        if (t >= dq_pkg::REM_W'(d))
            t = t - dq_pkg::REM_W'(d);
        return t;
    endfunction

    logic [dq_pkg::REM_W-1:0]   rem1_c;
    logic [dq_pkg::REM_W-1:0]   rem2_c;
    logic [dq_pkg::REM_W-1:0]   rem3_c;
    logic [dq_pkg::REM_W-1:0]   rem1_reg;
    logic [dq_pkg::REM_W-1:0]   rem2_reg;
    logic [dq_pkg::REM_W-1:0]   rem3_reg;
    logic [PAD-1:0]             dvd1_reg;
    logic [PAD-1:0]             dvd2_reg;
    logic [2:0]                 row_end_reg;
    logic [2:0]                 last_reg;

    always_comb
    begin
        rem1_c = '0;
        for (int i = 0; i < STEP; i++)
            rem1_c = rem_step(rem1_c, dvd0[PAD-1-i], eff_grp);
        rem2_c = rem1_reg;
        for (int i = 0; i < STEP; i++)
            rem2_c = rem_step(rem2_c, dvd1_reg[PAD-1-STEP-i], eff_grp);
        rem3_c = rem2_reg;
        for (int i = 0; i < STEP; i++)
            rem3_c = rem_step(rem3_c, dvd2_reg[PAD-1-2*STEP-i], eff_grp);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem1_reg    <= rem1_c;
            dvd1_reg    <= dvd0;
            rem2_reg    <= rem2_c;
            dvd2_reg    <= dvd1_reg;
            rem3_reg    <= rem3_c;
            row_end_reg <= {row_end_reg[1:0], row_end_c};
            last_reg    <= {last_reg[1:0], last_word};
        end
    end

    assign flags.row_end    = row_end_reg[2];
    assign flags.rem_zero   = (rem3_reg == '0);
    assign flags.matrix_end = last_reg[2];

endmodule

`default_nettype wire

>>> rtl/core/int4_group_dequantizer_top.sv
// int4_group_dequantizer_top: eight dq_lane copies, dq_pos, apb registers, output merge
// depends on dq_pkg, dq_word_if, dq_result_if, dq_lane, dq_pos
//
// channel     dir   handshake      payload
// word_ch     in    valid/ready    packed_word, scale_bits, bias_bits, last_word
// result_ch   out   valid/ready    weight_0..weight_7, row_end, group_end, matrix_end
// apb         in    psel/penable   row_words at 0x0, group_words at 0x4
//
// one item per cycle sustained while the output register is empty or result_ch is ready;
// an accepted word passes the three lane stages (multiply, align/add, round), then the output register
// all stages advance together; a held result stalls the whole pipe, bubbles included
// reset clears valid bits, the word counter and the registers to 8 and 8
`default_nettype none

module int4_group_dequantizer_top #(
    parameter int MAX_ROW_WORDS = dq_pkg::MAX_ROW_WORDS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    dq_word_if.sink                         word_ch,
    dq_result_if.source                     result_ch,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dq_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dq_pkg::APB_DW-1:0]  pwdata,
    output logic      [dq_pkg::APB_DW-1:0]  prdata,
    output logic                            pready
);

    logic [dq_pkg::ROW_W-1:0]   row_words_reg;
    logic [dq_pkg::GRP_W-1:0]   group_words_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_words_reg   <= dq_pkg::ROW_WORDS_RST;
            group_words_reg <= dq_pkg::GROUP_WORDS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                dq_pkg::REG_ROW_WORDS:   row_words_reg   <= pwdata[dq_pkg::ROW_W-1:0];
                dq_pkg::REG_GROUP_WORDS: group_words_reg <= pwdata[dq_pkg::GRP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            dq_pkg::REG_ROW_WORDS:   prdata = dq_pkg::APB_DW'(row_words_reg);
            dq_pkg::REG_GROUP_WORDS: prdata = dq_pkg::APB_DW'(group_words_reg);
            default:                 prdata = '0;
        endcase
    end

    // pipeline control
    logic       en;
    logic       accept;
    logic [2:0] v_reg;
    logic       out_valid_reg;

    assign en            = !out_valid_reg || result_ch.ready;
    assign accept        = word_ch.valid && en;
    assign word_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[1:0], accept};
            out_valid_reg <= v_reg[2];
        end
    end

    logic [dq_pkg::FP_W-1:0] lane_res [dq_pkg::LANES];

    for (genvar g = 0; g < dq_pkg::LANES; g++)
    begin : g_lane
        dq_lane u_lane (
            .clk        (clk),
            .en         (en),
            .nibble     (word_ch.packed_word[g*dq_pkg::NIB_W +: dq_pkg::NIB_W]),
            .scale_bits (word_ch.scale_bits),
            .bias_bits  (word_ch.bias_bits),
            .result     (lane_res[g])
        );
    end

    dq_pkg::pos_flags_t pos_flags;

    dq_pos #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .accept      (accept),
        .last_word   (word_ch.last_word),
        .row_words   (row_words_reg),
        .group_words (group_words_reg),
        .flags       (pos_flags)
    );

    // merge lanes and flags into the output register
    logic [dq_pkg::FP_W-1:0] weight_reg [dq_pkg::LANES];
    logic                    row_end_reg;
    logic                    group_end_reg;
    logic                    matrix_end_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < dq_pkg::LANES; i++)
                weight_reg[i] <= lane_res[i];
            row_end_reg    <= pos_flags.row_end;
            group_end_reg  <= pos_flags.row_end || pos_flags.rem_zero;
            matrix_end_reg <= pos_flags.matrix_end;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.weight_0   = weight_reg[0];
    assign result_ch.weight_1   = weight_reg[1];
    assign result_ch.weight_2   = weight_reg[2];
    assign result_ch.weight_3   = weight_reg[3];
    assign result_ch.weight_4   = weight_reg[4];
    assign result_ch.weight_5   = weight_reg[5];
    assign result_ch.weight_6   = weight_reg[6];
    assign result_ch.weight_7   = weight_reg[7];
    assign result_ch.row_end    = row_end_reg;
    assign result_ch.group_end  = group_end_reg;
    assign result_ch.matrix_end = matrix_end_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        word_ch.valid && word_ch.ready |=> v_reg[0])
        else $error("accepted item did not enter the pipe");

    a_row_implies_group: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (!result_ch.row_end || result_ch.group_end))
        else $error("row end without group end");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> word_ch.ready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

>>> test/tb.sv
// tb: self-checking bench for int4_group_dequantizer_top; predicts each fp32 weight with an
// integer soft-float model or, for typed directed rows, a table value, and the row/group
// flags with its own word counter; depends on dq_pkg, dq_word_if, dq_result_if and the rtl under rtl/core
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dq_pkg::WORD_W-1:0] word;
        logic [dq_pkg::BF_W-1:0]   scale;
        logic [dq_pkg::BF_W-1:0]   bias;
        logic                      last;
    } word_item_t;

    typedef struct packed {
        logic [dq_pkg::LANES-1:0][dq_pkg::FP_W-1:0] lanes;
        logic                                       row_end;
        logic                                       group_end;
        logic                                       matrix_end;
    } weights_t;

    typedef struct packed {
        word_item_t                item;
        logic                      typed;
        logic [dq_pkg::FP_W-1:0]   lane_val;
    } dir_row_t;

    typedef enum logic [1:0] {FP_ZERO, FP_FIN, FP_INF, FP_NAN} fp_kind_t;

    localparam int HOLD_CYCLES = 200;
    localparam int NUM_PHASES  = 9;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [dq_pkg::APB_AW-1:0] paddr;
    logic [dq_pkg::APB_DW-1:0] pwdata;
    logic [dq_pkg::APB_DW-1:0] prdata;
    logic pready;

    dq_word_if   word_ch ();
    dq_result_if result_ch ();

    int4_group_dequantizer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .word_ch  (word_ch.sink),
        .result_ch(result_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    weights_t    expected_weights[$];
    int          errors;
    logic [dq_pkg::ROW_W-1:0] row_words_cfg;
    logic [dq_pkg::GRP_W-1:0] group_words_cfg;
    int          word_pos;
    logic        hold_req;
    logic        steady;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- soft-float predictor ----------------

    function automatic logic [dq_pkg::FP_W-1:0] fp_round(input logic s, input logic [63:0] mag,
                                                         input int e);
        int p;
        int lsb;
        int sh;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        if (mag == 64'd0)
            return {s, 31'd0};
        p = 63;
        while (!mag[p])
            p--;
        lsb = p + e - 23;
        if (lsb < -149)
            lsb = -149;
        sh = lsb - e;
        if (sh <= 0)
            m = mag << (-sh);
        else if (sh > 62)
            m = 64'd0;
        else
        begin
            m = mag >> sh;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0]))
                m = m + 64'd1;
        end
        if (m[24])
        begin
            m = m >> 1;
            lsb++;
        end
        if (m[23])
        begin
            if (lsb + 150 >= 255)
                return {s, dq_pkg::EXP_MAX, 23'd0};
            return {s, 8'(lsb + 150), m[22:0]};
        end
        return {s, 8'h00, m[22:0]};
    endfunction

    function automatic fp_kind_t fp_split(input logic [dq_pkg::FP_W-1:0] f,
                                          output logic [63:0] mag, output int e);
        mag = 64'd0;
        e = 0;
        if (f[30:23] == dq_pkg::EXP_MAX)
            return (f[22:0] != 0) ? FP_NAN : FP_INF;
        if (f[30:23] == 8'h00)
        begin
            if (f[22:0] == 0)
                return FP_ZERO;
            mag = {41'd0, f[22:0]};
            e = -149;
            return FP_FIN;
        end
        mag = {40'd0, 1'b1, f[22:0]};
        e = int'(f[30:23]) - 150;
        return FP_FIN;
    endfunction

    function automatic logic [dq_pkg::FP_W-1:0] fp_scale_nibble(input logic [3:0] q,
                                                                input logic [dq_pkg::FP_W-1:0] sc);
        logic [63:0] mag;
        int e;
        fp_kind_t k;
        k = fp_split(sc, mag, e);
        if (k == FP_NAN)
            return dq_pkg::FP_QNAN;
        if (k == FP_INF)
            return (q == 0) ? dq_pkg::FP_QNAN : {sc[31], dq_pkg::EXP_MAX, 23'd0};
        if (k == FP_ZERO || q == 0)
            return {sc[31], 31'd0};
        return fp_round(sc[31], mag * q, e);
    endfunction

    function automatic logic [dq_pkg::FP_W-1:0] fp_sum(input logic [dq_pkg::FP_W-1:0] a,
                                                       input logic [dq_pkg::FP_W-1:0] b);
        logic [63:0] ma, mb, mh, ml, r;
        int ea, eb, eh, el, ec, d;
        logic sh_s, sl_s, rs;
        fp_kind_t ka, kb;
        ka = fp_split(a, ma, ea);
        kb = fp_split(b, mb, eb);
        if (ka == FP_NAN || kb == FP_NAN)
            return dq_pkg::FP_QNAN;
        if (ka == FP_INF && kb == FP_INF)
            return (a[31] != b[31]) ? dq_pkg::FP_QNAN : a;
        if (ka == FP_INF)
            return a;
        if (kb == FP_INF)
            return b;
        if (ka == FP_ZERO && kb == FP_ZERO)
            return {a[31] & b[31], 31'd0};
        if (ka == FP_ZERO)
            return b;
        if (kb == FP_ZERO)
            return a;
        while (!ma[23])
        begin
            ma = ma << 1;
            ea--;
        end
        while (!mb[23])
        begin
            mb = mb << 1;
            eb--;
        end
        if (ea >= eb)
        begin
            mh = ma; eh = ea; sh_s = a[31];
            ml = mb; el = eb; sl_s = b[31];
        end
        else
        begin
            mh = mb; eh = eb; sh_s = b[31];
            ml = ma; el = ea; sl_s = a[31];
        end
        ec = eh - 30;
        mh = mh << 30;
        d = el - ec;
        if (d >= 0)
            ml = ml << d;
        else if (-d > 40)
            ml = 64'd1;
        else
            ml = (ml >> (-d)) | {63'd0, |(ml & ((64'd1 << (-d)) - 64'd1))};
        if (sh_s == sl_s)
        begin
            r = mh + ml;
            rs = sh_s;
        end
        else if (mh > ml)
        begin
            r = mh - ml;
            rs = sh_s;
        end
        else if (ml > mh)
        begin
            r = ml - mh;
            rs = sl_s;
        end
        else
            return {dq_pkg::FP_W{1'b0}};
        return fp_round(rs, r, ec);
    endfunction

    function automatic weights_t dequant_word(input word_item_t it);
        weights_t w;
        int eff_row;
        int eff_grp;
        int nxt;
        for (int i = 0; i < dq_pkg::LANES; i++)
            w.lanes[i] = fp_sum(fp_scale_nibble(it.word[4*i +: 4], {it.scale, 16'd0}),
                                {it.bias, 16'd0});
        eff_row = (row_words_cfg == 0) ? 1 : int'(row_words_cfg);
        if (eff_row > dq_pkg::MAX_ROW_WORDS_DEF)
            eff_row = dq_pkg::MAX_ROW_WORDS_DEF;
        eff_grp = (group_words_cfg == 0) ? 1 : int'(group_words_cfg);
        nxt = word_pos + 1;
        w.row_end = (nxt >= eff_row);
        w.group_end = w.row_end || (nxt % eff_grp == 0);
        w.matrix_end = it.last;
        word_pos = (w.row_end || it.last) ? 0 : nxt;
        return w;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [dq_pkg::BF_W-1:0] rand_bf16();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return dq_pkg::BF_W'($urandom);
        if (r < 24)
            return {1'($urandom), 15'd0};
        if (r < 27)
            return {1'($urandom), 8'hFF, 7'($urandom_range(0, 1))};
        return {1'($urandom), 8'($urandom_range(117, 137)), 7'($urandom)};
    endfunction

    task automatic apb_write(input logic reg_sel, input logic [dq_pkg::APB_DW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == dq_pkg::REG_ROW_WORDS)
            row_words_cfg = value[dq_pkg::ROW_W-1:0];
        else
            group_words_cfg = value[dq_pkg::GRP_W-1:0];
    endtask

    task automatic push_word(input word_item_t it, input logic typed,
                             input logic [dq_pkg::FP_W-1:0] lane_val);
        int gap;
        weights_t w;
        gap = pick_gap();
        if (gap > 0)
        begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_ch.valid       <= 1'b1;
        word_ch.packed_word <= it.word;
        word_ch.scale_bits  <= it.scale;
        word_ch.bias_bits   <= it.bias;
        word_ch.last_word   <= it.last;
        do
            @(negedge clk);
        while (!word_ch.ready);
        w = dequant_word(it);
        if (typed)
            for (int i = 0; i < dq_pkg::LANES; i++)
                w.lanes[i] = lane_val;
        expected_weights.insert(expected_weights.size(), w);
        @(posedge clk);
    endtask

    task automatic drain_results();
        word_ch.valid <= 1'b0;
        while (expected_weights.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // ---------------- result checker ----------------

    initial begin
        weights_t w;
        forever
        begin
            @(negedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_weights.size() == 0)
                begin
                    $display("%0t: unexpected result item", $time);
                    errors++;
                end
                else
                begin
                    w = expected_weights.pop_front();
                    for (int i = 0; i < dq_pkg::LANES; i++)
                    begin
                        logic [dq_pkg::FP_W-1:0] got;
                        case (i)
                            0: got = result_ch.weight_0;
                            1: got = result_ch.weight_1;
                            2: got = result_ch.weight_2;
                            3: got = result_ch.weight_3;
                            4: got = result_ch.weight_4;
                            5: got = result_ch.weight_5;
                            6: got = result_ch.weight_6;
                            default: got = result_ch.weight_7;
                        endcase
                        if (got !== w.lanes[i])
                        begin
                            $display("%0t: weight_%0d expected %h got %h",
                                     $time, i, w.lanes[i], got);
                            errors++;
                        end
                    end
                    if (result_ch.row_end !== w.row_end)
                    begin
                        $display("%0t: row_end expected %b got %b",
                                 $time, w.row_end, result_ch.row_end);
                        errors++;
                    end
                    if (result_ch.group_end !== w.group_end)
                    begin
                        $display("%0t: group_end expected %b got %b",
                                 $time, w.group_end, result_ch.group_end);
                        errors++;
                    end
                    if (result_ch.matrix_end !== w.matrix_end)
                    begin
                        $display("%0t: matrix_end expected %b got %b",
                                 $time, w.matrix_end, result_ch.matrix_end);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------- result receiver ----------------

    initial begin
        int len;
        result_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (steady || $urandom_range(0, 99) < 60)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(6, 40);
                result_ch.ready <= 1'b0;
                repeat (len) @(posedge clk);
            end
        end
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin
        dir_row_t dir_tab[16];
        int row_set[NUM_PHASES];
        int grp_set[NUM_PHASES];
        word_item_t it;

        dir_tab = '{
            '{'{32'h0000_0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, 32'h0000_0000},
            '{'{32'hFFFF_FFFF, 16'h3F80, 16'hBF80, 1'b0}, 1'b1, 32'h4160_0000},
            '{'{32'h1234_5678, 16'h7FC1, 16'h3F80, 1'b0}, 1'b1, dq_pkg::FP_QNAN},
            '{'{32'h0000_0000, 16'h7F80, 16'h0000, 1'b0}, 1'b1, dq_pkg::FP_QNAN},
            '{'{32'h1111_1111, 16'hFF80, 16'h7F80, 1'b0}, 1'b1, dq_pkg::FP_QNAN},
            '{'{32'hFFFF_FFFF, 16'h7F7F, 16'h0000, 1'b0}, 1'b1, 32'h7F80_0000},
            '{'{32'h1111_1111, 16'h0001, 16'h0000, 1'b0}, 1'b1, 32'h0001_0000},
            '{'{32'h0000_0000, 16'h8000, 16'h8000, 1'b0}, 1'b1, 32'h8000_0000},
            '{'{32'hFFFF_FFFF, 16'h3F80, 16'hC170, 1'b0}, 1'b1, 32'h0000_0000},
            '{'{32'h7654_3210, 16'h3F80, 16'h0000, 1'b0}, 1'b0, 32'h0},
            '{'{32'hFEDC_BA98, 16'hBFC0, 16'h4B80, 1'b0}, 1'b0, 32'h0},
            '{'{32'hA5A5_A5A5, 16'h3F81, 16'h3301, 1'b0}, 1'b0, 32'h0},
            '{'{32'h5A5A_5A5A, 16'h0080, 16'h8001, 1'b0}, 1'b0, 32'h0},
            '{'{32'h0F0F_0F0F, 16'hFF7F, 16'hFF7F, 1'b0}, 1'b0, 32'h0},
            '{'{32'h3333_3333, 16'h4000, 16'h7F80, 1'b1}, 1'b1, 32'h7F80_0000},
            '{'{32'hCCCC_CCCC, 16'h3E00, 16'h0000, 1'b0}, 1'b0, 32'h0}
        };
        row_set = '{8, 0, 1, 3, 13, 4096, 8191, 5000, 16};
        grp_set = '{8, 0, 1, 2, 5, 64, 127, 3, 8};

        errors = 0;
        word_pos = 0;
        row_words_cfg = dq_pkg::ROW_WORDS_RST;
        group_words_cfg = dq_pkg::GROUP_WORDS_RST;
        hold_req = 1'b0;
        steady = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        word_ch.valid = 1'b0;
        word_ch.packed_word = '0;
        word_ch.scale_bits = '0;
        word_ch.bias_bits = '0;
        word_ch.last_word = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            push_word(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].lane_val);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            apb_write(dq_pkg::REG_ROW_WORDS, dq_pkg::APB_DW'(row_set[ph]));
            apb_write(dq_pkg::REG_GROUP_WORDS, dq_pkg::APB_DW'(grp_set[ph]));
            steady = (ph % 3 == 2);
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < 115; n++)
            begin
                it.word = $urandom;
                it.scale = rand_bf16();
                it.bias = rand_bf16();
                it.last = ($urandom_range(0, 39) == 0);
                push_word(it, 1'b0, '0);
            end
            drain_results();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/dq_pkg.sv
rtl/core/dq_word_if.sv
rtl/core/dq_result_if.sv
rtl/core/dq_lane.sv
rtl/core/dq_pos.sv
rtl/core/int4_group_dequantizer_top.sv
test/tb.sv
